>>> rtl/slgs_pkg.sv
// ----------------------------------------------------------------------------
// Source localization gradient step: shared package
// Types, constants and register indexes shared by the gradient step modules.
// ----------------------------------------------------------------------------
package slgs_pkg;

  localparam int FRAC_BITS = 12;
  localparam int IO_W = 21;
  localparam int LIGHT_W = 25;
  localparam int DIFF_W = IO_W + 1;
  localparam int PROD_W = 54;
  localparam int STEP_SHIFT = 6;

  localparam logic [27:0] A_VAL = 28'd196608000;
  localparam logic [31:0] B_VAL = 32'd196608;
  localparam logic [39:0] F_NUM = 40'd805306368000;

  typedef enum logic [2:0] {
    REG_NODE_X  = 3'd0,
    REG_NODE_Y  = 3'd1,
    REG_X_UPPER = 3'd2,
    REG_X_LOWER = 3'd3,
    REG_Y_UPPER = 3'd4,
    REG_Y_LOWER = 3'd5,
    REG_Z_UPPER = 3'd6,
    REG_Z_LOWER = 3'd7
  } cfg_reg_t;

  localparam logic signed [IO_W-1:0] RST_XY_UPPER = 21'sd368640;
  localparam logic signed [IO_W-1:0] RST_XY_LOWER = -21'sd122880;
  localparam logic signed [IO_W-1:0] RST_Z_UPPER  = 21'sd122880;
  localparam logic signed [IO_W-1:0] RST_Z_LOWER  = 21'sd12288;

  typedef struct packed {
    logic signed [IO_W-1:0] hi;
    logic signed [IO_W-1:0] lo;
  } bounds_t;

  typedef struct packed {
    logic en;
    logic valid;
  } lane_ctl_t;

endpackage

>>> rtl/slgs_div.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, with side data carried along.
// ----------------------------------------------------------------------------
module slgs_div #(
  parameter int W = 64,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [W-1:0]  quo,
  output logic [SW-1:0] side_out
);

  logic [W-1:0]  r_r [1:W];
  logic [W-1:0]  n_r [1:W];
  logic [W-1:0]  d_r [1:W];
  logic [W-1:0]  q_r [1:W];
  logic [SW-1:0] s_r [1:W];
  logic          v_r [1:W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W-1:0]  r_i, n_i, d_i, q_i;
    logic [SW-1:0] s_i;
    logic          v_i;
    logic [W:0]    trial, sub;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_i = '0;
      assign n_i = num;
      assign d_i = den;
      assign q_i = '0;
      assign s_i = side_in;
      assign v_i = in_valid;
    end else begin : g_rest
      assign r_i = r_r[k];
      assign n_i = n_r[k];
      assign d_i = d_r[k];
      assign q_i = q_r[k];
      assign s_i = s_r[k];
      assign v_i = v_r[k];
    end

    assign trial = {r_i, n_i[W-1]};
    assign sub = trial - {1'b0, d_i};
    assign ge = ~sub[W];

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k+1] <= ge ? sub[W-1:0] : trial[W-1:0];
        n_r[k+1] <= n_i << 1;
        d_r[k+1] <= d_i;
        q_r[k+1] <= {q_i[W-2:0], ge};
        s_r[k+1] <= s_i;
      end
    end
  end

  assign out_valid = v_r[W];
  assign quo = q_r[W];
  assign side_out = s_r[W];

endmodule

>>> rtl/slgs_lane.sv
// ----------------------------------------------------------------------------
// Gradient step lane
// Forms one coordinate's step from the shared terms, divides and clamps it.
// ----------------------------------------------------------------------------
module slgs_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  slgs_pkg::lane_ctl_t                  ctl,
  input  logic signed [slgs_pkg::PROD_W-1:0]   p,
  input  logic signed [slgs_pkg::DIFF_W-1:0]   d,
  input  logic signed [slgs_pkg::IO_W-1:0]     est,
  input  logic signed [63:0]                   gsq,
  input  slgs_pkg::bounds_t                    bounds,
  output logic                                 out_valid,
  output logic signed [slgs_pkg::IO_W-1:0]     res
);

  localparam int SW = slgs_pkg::IO_W + 2;

  logic signed [49:0] plo;
  logic signed [48:0] phi;
  logic signed [63:0] gsq1;
  logic signed [slgs_pkg::IO_W-1:0] est1;
  logic v1;

  logic signed [63:0] num;
  logic [63:0] un, ud;
  logic neg, zero;
  logic signed [slgs_pkg::IO_W-1:0] est2;
  logic v2;

  logic dv;
  logic [63:0] dq;
  logic [SW-1:0] dside;

  logic signed [63:0] qv;
  logic signed [slgs_pkg::IO_W-1:0] est3;
  logic v3;

  logic signed [63:0] qs, stepv, diff64, clamp, hi64, lo64;
  logic [63:0] qmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (ctl.en) begin
      v1 <= ctl.valid;
      v2 <= v1;
      v3 <= dv;
      out_valid <= v3;
    end
  end

  assign num = ({{15{phi[48]}}, phi} <<< 27) + {{14{plo[49]}}, plo};

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      plo <= $signed({1'b0, p[26:0]}) * d;
      phi <= $signed(p[53:27]) * d;
      gsq1 <= gsq;
      est1 <= est;
      un <= num[63] ? 64'(-num) : num;
      ud <= gsq1[63] ? 64'(-gsq1) : gsq1;
      neg <= num[63] ^ gsq1[63];
      zero <= (gsq1 == 64'sd0);
      est2 <= est1;
    end
  end

  slgs_div #(.W(64), .SW(SW)) u_div (
    .clk(clk),
    .rst(rst),
    .en(ctl.en),
    .in_valid(v2),
    .num(un),
    .den(ud),
    .side_in({neg, zero, est2}),
    .out_valid(dv),
    .quo(dq),
    .side_out(dside)
  );

  assign qmag = dside[SW-1] ? 64'(-dq) : dq;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      qv <= dside[SW-2] ? 64'sd0 : $signed(qmag);
      est3 <= dside[slgs_pkg::IO_W-1:0];
    end
  end

  assign hi64 = 64'(bounds.hi);
  assign lo64 = 64'(bounds.lo);

  always_comb begin
    qs = qv >>> slgs_pkg::FRAC_BITS;
    stepv = (qs <<< slgs_pkg::STEP_SHIFT) >>> slgs_pkg::FRAC_BITS;
    diff64 = 64'(est3) - stepv;
    clamp = (diff64 > hi64) ? hi64 : diff64;
    if (clamp < lo64) begin
      clamp = lo64;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      res <= clamp[slgs_pkg::IO_W-1:0];
    end
  end

endmodule

>>> rtl/source_localization_gradient_step_core.sv
// ----------------------------------------------------------------------------
// Source localization gradient step core
// One gradient step of a light-source position estimate with box clamping.
// ----------------------------------------------------------------------------
// Channel  Signals                                   Direction
// in       in_valid, in_stall, est_x/y/z, light_level  request in
// out      out_valid, out_stall, next_x/y/z            request out
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data   register write in
//
// One request enters per cycle while in_stall is low.
// The latency is set by the 40-stage distance divider and the 64-stage lane dividers.
// Reset clears all valid flags and loads the register defaults.
// A stalled result freezes the whole pipeline and stalls the input side.
// ----------------------------------------------------------------------------
module source_localization_gradient_step_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [slgs_pkg::IO_W-1:0]       est_x,
  input  logic signed [slgs_pkg::IO_W-1:0]       est_y,
  input  logic signed [slgs_pkg::IO_W-1:0]       est_z,
  input  logic signed [slgs_pkg::LIGHT_W-1:0]    light_level,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [slgs_pkg::IO_W-1:0]       next_x,
  output logic signed [slgs_pkg::IO_W-1:0]       next_y,
  output logic signed [slgs_pkg::IO_W-1:0]       next_z,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [2:0]                             cfg_index,
  input  logic signed [slgs_pkg::IO_W-1:0]       cfg_data
);

  localparam int IW = slgs_pkg::IO_W;
  localparam int DW = slgs_pkg::DIFF_W;
  localparam int LW = slgs_pkg::LIGHT_W;
  localparam int SIDE_W = 64 + 3 * DW + 3 * IW + LW;

  logic signed [IW-1:0] node_x, node_y;
  slgs_pkg::bounds_t bounds [3];

  logic adv;
  logic [2:0] lane_valid;

  logic signed [DW-1:0] d1 [3], d2 [3], d3 [3], d4 [3], d5 [3];
  logic signed [IW-1:0] e1 [3], e2 [3], e3 [3], e4 [3], e5 [3];
  logic signed [LW-1:0] l1, l2, l3, l4, l5;
  logic v1, v2, v3, v4, v5;
  logic signed [43:0] sq [3];
  logic [43:0] norm;
  logic [31:0] g3, g4;
  logic [63:0] gg4;
  logic signed [63:0] gsq4, gsq5, fgsq;

  logic fv;
  logic [39:0] fq;
  logic [SIDE_W-1:0] fside;
  logic signed [LW:0] rdiff;
  logic signed [slgs_pkg::PROD_W-1:0] p5;
  logic signed [slgs_pkg::PROD_W:0] pfull;
  logic signed [IW-1:0] lane_res [3];
  logic signed [IW-1:0] est_in [3];

  assign cfg_ready = 1'b1;
  assign adv = ~(out_valid & out_stall);
  assign in_stall = ~adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_x <= '0;
      node_y <= '0;
      bounds[0] <= '{hi: slgs_pkg::RST_XY_UPPER, lo: slgs_pkg::RST_XY_LOWER};
      bounds[1] <= '{hi: slgs_pkg::RST_XY_UPPER, lo: slgs_pkg::RST_XY_LOWER};
      bounds[2] <= '{hi: slgs_pkg::RST_Z_UPPER, lo: slgs_pkg::RST_Z_LOWER};
    end else if (cfg_valid) begin
      case (slgs_pkg::cfg_reg_t'(cfg_index))
        slgs_pkg::REG_NODE_X:  node_x <= cfg_data;
        slgs_pkg::REG_NODE_Y:  node_y <= cfg_data;
        slgs_pkg::REG_X_UPPER: bounds[0].hi <= cfg_data;
        slgs_pkg::REG_X_LOWER: bounds[0].lo <= cfg_data;
        slgs_pkg::REG_Y_UPPER: bounds[1].hi <= cfg_data;
        slgs_pkg::REG_Y_LOWER: bounds[1].lo <= cfg_data;
        slgs_pkg::REG_Z_UPPER: bounds[2].hi <= cfg_data;
        slgs_pkg::REG_Z_LOWER: bounds[2].lo <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= fv;
    end
  end

  assign est_in[0] = est_x;
  assign est_in[1] = est_y;
  assign est_in[2] = est_z;

  assign norm = sq[0][43:0] + sq[1][43:0] + sq[2][43:0];
  assign gsq4 = $signed(gg4) >>> slgs_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (adv) begin
      d1[0] <= DW'(est_x) - DW'(node_x);
      d1[1] <= DW'(est_y) - DW'(node_y);
      d1[2] <= DW'(est_z);
      l1 <= light_level;
      l2 <= l1;
      l3 <= l2;
      l4 <= l3;
      g3 <= norm[43:12] + slgs_pkg::B_VAL;
      g4 <= g3;
      gg4 <= 64'(g3) * 64'(g3);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_front
    always_ff @(posedge clk) begin
      if (adv) begin
        e1[i] <= est_in[i];
        e2[i] <= e1[i];
        e3[i] <= e2[i];
        e4[i] <= e3[i];
        d2[i] <= d1[i];
        d3[i] <= d2[i];
        d4[i] <= d3[i];
        sq[i] <= d1[i] * d1[i];
      end
    end
  end

  slgs_div #(.W(40), .SW(SIDE_W)) u_fdiv (
    .clk(clk),
    .rst(rst),
    .en(adv),
    .in_valid(v4),
    .num(slgs_pkg::F_NUM),
    .den({8'd0, g4}),
    .side_in({gsq4, d4[0], d4[1], d4[2], e4[0], e4[1], e4[2], l4}),
    .out_valid(fv),
    .quo(fq),
    .side_out(fside)
  );

  always_comb begin
    {fgsq, d5[0], d5[1], d5[2], e5[0], e5[1], e5[2], l5} = fside;
    rdiff = (LW + 1)'(l5) - $signed({1'b0, fq[LW-2:0]});
    pfull = $signed({1'b0, slgs_pkg::A_VAL}) * rdiff;
  end

  logic signed [DW-1:0] d6 [3];
  logic signed [IW-1:0] e6 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      p5 <= pfull[slgs_pkg::PROD_W-1:0];
      gsq5 <= fgsq;
      d6 <= d5;
      e6 <= e5;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    slgs_lane u_lane (
      .clk(clk),
      .rst(rst),
      .ctl('{en: adv, valid: v5}),
      .p(p5),
      .d(d6[i]),
      .est(e6[i]),
      .gsq(gsq5),
      .bounds(bounds[i]),
      .out_valid(lane_valid[i]),
      .res(lane_res[i])
    );
  end

  assign out_valid = lane_valid[0];
  assign next_x = lane_res[0];
  assign next_y = lane_res[1];
  assign next_z = lane_res[2];

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    lane_valid[1] == lane_valid[0] && lane_valid[2] == lane_valid[0])
    else $error("lanes out of step");

endmodule

>>> test/tb_source_localization_gradient_step_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gradient step core testbench
// Drives position estimates and light readings through the core, predicts
// every updated and clamped position in 64-bit wrapping arithmetic, and
// compares each result in order. Bounds and node position are reprogrammed
// between phases, and both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module tb_source_localization_gradient_step_core;

  localparam int LATENCY = 113;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [slgs_pkg::IO_W-1:0] x;
    logic signed [slgs_pkg::IO_W-1:0] y;
    logic signed [slgs_pkg::IO_W-1:0] z;
  } position_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [slgs_pkg::IO_W-1:0] est_x = '0, est_y = '0, est_z = '0;
  logic signed [slgs_pkg::LIGHT_W-1:0] light_level = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [slgs_pkg::IO_W-1:0] next_x, next_y, next_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic signed [slgs_pkg::IO_W-1:0] cfg_data = '0;

  source_localization_gradient_step_core uut (.*);

  longint bound_reg [8];
  position_t expected_positions [$];
  int mismatches = 0;
  int requests_sent = 0;
  int positions_checked = 0;
  int config_writes = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  bit random_stall = 1'b1;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("tb_source_localization_gradient_step_core failed");
      $finish;
    end
  end

  function automatic longint sar(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint div_trunc(longint n, longint d);
    if (d == 0) return 0;
    if (n == 64'sh8000_0000_0000_0000 && d == -1) return n;
    return n / d;
  endfunction

  function automatic position_t step_position(logic signed [slgs_pkg::IO_W-1:0] ex,
      logic signed [slgs_pkg::IO_W-1:0] ey, logic signed [slgs_pkg::IO_W-1:0] ez,
      logic signed [slgs_pkg::LIGHT_W-1:0] light);
    longint est [3];
    longint node [3];
    longint res [3];
    longint a, b, norm, g, f, gsq, diff_rf, num, q, stepv, d;
    position_t p;
    a = 64'sd48000 <<< slgs_pkg::FRAC_BITS;
    b = 64'sd48 <<< slgs_pkg::FRAC_BITS;
    est[0] = longint'(ex);
    est[1] = longint'(ey);
    est[2] = longint'(ez);
    node[0] = bound_reg[slgs_pkg::REG_NODE_X];
    node[1] = bound_reg[slgs_pkg::REG_NODE_Y];
    node[2] = 0;
    norm = 0;
    for (int i = 0; i < 3; i++) begin
      d = est[i] - node[i];
      norm = norm + d * d;
    end
    g = sar(norm, slgs_pkg::FRAC_BITS) + b;
    f = div_trunc(a <<< slgs_pkg::FRAC_BITS, g);
    gsq = sar(g * g, slgs_pkg::FRAC_BITS);
    diff_rf = longint'(light) - f;
    for (int i = 0; i < 3; i++) begin
      num = a * diff_rf * (est[i] - node[i]);
      q = sar(div_trunc(num, gsq), slgs_pkg::FRAC_BITS);
      stepv = sar(64 * q, slgs_pkg::FRAC_BITS);
      res[i] = est[i] - stepv;
      if (res[i] > bound_reg[2 + 2 * i]) res[i] = bound_reg[2 + 2 * i];
      if (res[i] < bound_reg[3 + 2 * i]) res[i] = bound_reg[3 + 2 * i];
    end
    p.x = res[0][slgs_pkg::IO_W-1:0];
    p.y = res[1][slgs_pkg::IO_W-1:0];
    p.z = res[2][slgs_pkg::IO_W-1:0];
    return p;
  endfunction

  task automatic send_request(logic signed [slgs_pkg::IO_W-1:0] ex,
      logic signed [slgs_pkg::IO_W-1:0] ey, logic signed [slgs_pkg::IO_W-1:0] ez,
      logic signed [slgs_pkg::LIGHT_W-1:0] light);
    int idle;
    idle = $urandom_range(0, 8) * ($urandom_range(0, 3) == 0);
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    est_x <= ex;
    est_y <= ey;
    est_z <= ez;
    light_level <= light;
    do @(posedge clk); while (in_stall);
    expected_positions.push_back(step_position(ex, ey, ez, light));
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_positions.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_bound(slgs_pkg::cfg_reg_t idx,
      logic signed [slgs_pkg::IO_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    bound_reg[idx] = longint'(value);
    config_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_random(int count, bit near);
    logic signed [slgs_pkg::IO_W-1:0] ex, ey, ez;
    logic signed [slgs_pkg::LIGHT_W-1:0] light;
    for (int n = 0; n < count; n++) begin
      if (near) begin
        ex = 21'(bound_reg[slgs_pkg::REG_NODE_X] +
                 $signed(21'($urandom_range(0, 32767)) - 21'sd16384));
        ey = 21'(bound_reg[slgs_pkg::REG_NODE_Y] +
                 $signed(21'($urandom_range(0, 32767)) - 21'sd16384));
        ez = $signed(21'($urandom_range(0, 131071)));
        light = $signed(25'($urandom_range(0, 8388607)) - 25'sd4194304);
      end else begin
        ex = 21'($urandom);
        ey = 21'($urandom);
        ez = 21'($urandom);
        light = 25'($urandom);
      end
      send_request(ex, ey, ez, light);
    end
  endtask

  task automatic test_directed();
    logic signed [slgs_pkg::IO_W-1:0] emax, emin;
    logic signed [slgs_pkg::LIGHT_W-1:0] lmax, lmin;
    emax = {1'b0, {(slgs_pkg::IO_W-1){1'b1}}};
    emin = {1'b1, {(slgs_pkg::IO_W-1){1'b0}}};
    lmax = {1'b0, {(slgs_pkg::LIGHT_W-1){1'b1}}};
    lmin = {1'b1, {(slgs_pkg::LIGHT_W-1){1'b0}}};
    send_request('0, '0, '0, '0);
    send_request(emax, emax, emax, lmax);
    send_request(emin, emin, emin, lmin);
    send_request(emax, emin, emax, lmin);
    send_request(emin, emax, emin, lmax);
    send_request(-21'sd1, -21'sd1, -21'sd1, -25'sd1);
    send_request(21'sd4096, 21'sd8192, 21'sd40960, 25'sd4096000);
    send_request(21'sd200000, -21'sd100000, 21'sd50000, -25'sd1000000);
    send_request('0, '0, 21'sd4096, lmax);
    send_request(21'sd100, 21'sd100, 21'sd100, 25'sd0);
    wait_drained();
  endtask

  task automatic test_wide_box();
    write_bound(slgs_pkg::REG_NODE_X, 21'sd81920);
    write_bound(slgs_pkg::REG_NODE_Y, -21'sd40960);
    write_bound(slgs_pkg::REG_X_UPPER, {1'b0, {(slgs_pkg::IO_W-1){1'b1}}});
    write_bound(slgs_pkg::REG_X_LOWER, {1'b1, {(slgs_pkg::IO_W-1){1'b0}}});
    write_bound(slgs_pkg::REG_Y_UPPER, {1'b0, {(slgs_pkg::IO_W-1){1'b1}}});
    write_bound(slgs_pkg::REG_Y_LOWER, {1'b1, {(slgs_pkg::IO_W-1){1'b0}}});
    write_bound(slgs_pkg::REG_Z_UPPER, {1'b0, {(slgs_pkg::IO_W-1){1'b1}}});
    write_bound(slgs_pkg::REG_Z_LOWER, {1'b1, {(slgs_pkg::IO_W-1){1'b0}}});
    send_random(350, 1'b1);
    send_random(150, 1'b0);
    wait_drained();
  endtask

  task automatic test_crossed_bounds();
    write_bound(slgs_pkg::REG_NODE_X, {1'b1, {(slgs_pkg::IO_W-1){1'b0}}});
    write_bound(slgs_pkg::REG_NODE_Y, {1'b0, {(slgs_pkg::IO_W-1){1'b1}}});
    write_bound(slgs_pkg::REG_X_UPPER, -21'sd4096);
    write_bound(slgs_pkg::REG_X_LOWER, 21'sd4096);
    write_bound(slgs_pkg::REG_Y_UPPER, 21'sd0);
    write_bound(slgs_pkg::REG_Y_LOWER, -21'sd8192);
    write_bound(slgs_pkg::REG_Z_UPPER, {1'b1, {(slgs_pkg::IO_W-1){1'b0}}});
    write_bound(slgs_pkg::REG_Z_LOWER, {1'b1, {(slgs_pkg::IO_W-1){1'b0}}});
    send_random(200, 1'b0);
    send_random(100, 1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    write_bound(slgs_pkg::REG_NODE_X, 21'sd0);
    write_bound(slgs_pkg::REG_NODE_Y, 21'sd0);
    write_bound(slgs_pkg::REG_X_UPPER, 21'sd368640);
    write_bound(slgs_pkg::REG_X_LOWER, -21'sd122880);
    write_bound(slgs_pkg::REG_Y_UPPER, 21'sd368640);
    write_bound(slgs_pkg::REG_Y_LOWER, -21'sd122880);
    write_bound(slgs_pkg::REG_Z_UPPER, 21'sd122880);
    write_bound(slgs_pkg::REG_Z_LOWER, 21'sd12288);
    random_stall = 1'b0;
    hold_off = 1'b1;
    send_random(200, 1'b1);
    if (hold_off) begin
      in_valid <= 1'b0;
      wait (hold_off == 1'b0);
      @(negedge clk);
    end
    random_stall = 1'b1;
    send_random(500, 1'b1);
    send_random(100, 1'b0);
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
      repeat (600) @(negedge clk);
      hold_off <= 1'b0;
      out_stall <= 1'b0;
    end else if (random_stall) begin
      out_stall <= ($urandom_range(0, 3) == 0) && ($urandom_range(0, 8) != 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    position_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_positions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %0d %0d %0d", next_x, next_y, next_z);
      end else begin
        want = expected_positions.pop_front();
        positions_checked++;
        if (next_x !== want.x || next_y !== want.y || next_z !== want.z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     want.x, want.y, want.z, next_x, next_y, next_z);
        end
      end
    end
  end

  initial begin
    bound_reg[slgs_pkg::REG_NODE_X] = 0;
    bound_reg[slgs_pkg::REG_NODE_Y] = 0;
    bound_reg[slgs_pkg::REG_X_UPPER] = longint'(slgs_pkg::RST_XY_UPPER);
    bound_reg[slgs_pkg::REG_X_LOWER] = longint'(slgs_pkg::RST_XY_LOWER);
    bound_reg[slgs_pkg::REG_Y_UPPER] = longint'(slgs_pkg::RST_XY_UPPER);
    bound_reg[slgs_pkg::REG_Y_LOWER] = longint'(slgs_pkg::RST_XY_LOWER);
    bound_reg[slgs_pkg::REG_Z_UPPER] = longint'(slgs_pkg::RST_Z_UPPER);
    bound_reg[slgs_pkg::REG_Z_LOWER] = longint'(slgs_pkg::RST_Z_LOWER);
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_wide_box();
    test_crossed_bounds();
    test_backpressure();
    $display("Sent %0d requests and checked %0d positions across %0d register writes,",
             requests_sent, positions_checked, config_writes);
    $display("covering reset, wide, crossed and default boxes and a long output stall.");
    if (mismatches == 0 && expected_positions.size() == 0) begin
      $display("tb_source_localization_gradient_step_core passed");
    end else begin
      $display("%0d mismatches, %0d results missing.", mismatches, expected_positions.size());
      $display("tb_source_localization_gradient_step_core failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/slgs_pkg.sv
rtl/slgs_div.sv
rtl/slgs_lane.sv
rtl/source_localization_gradient_step_core.sv
test/tb_source_localization_gradient_step_core.sv
